>>> rtl/epmd_pkg.sv
// ----------------------------------------------------------------------------
// epmd_pkg: shared definitions for the encoder PID motor drive
// Constants, register indexes, operand types and the encoder phase decode.
// ----------------------------------------------------------------------------
package epmd_pkg;

   // Fixed configuration of the drive.
   localparam int SPEED_WINDOW = 8;
   localparam int PWM_MAX      = 3600;
   localparam int FRICTION_PWM = 200;
   localparam int REF_MV       = 12000;

   localparam int RING_IW = $clog2(SPEED_WINDOW);
   localparam int QUOT_W  = $clog2(PWM_MAX + 1);
   localparam int DIV_CW  = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;

   // Shared multiplier operand widths.
   localparam int MUL_AW = 16;
   localparam int MUL_BW = 34;
   localparam int MUL_PW = 50;

   // Configuration port.
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 20;

   localparam logic [CSR_IW-1:0] CSR_CONTROL_MODE   = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_SPEED_TARGET   = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_MANUAL_COMMAND = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_GAIN_P         = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_GAIN_I         = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_GAIN_D         = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_INTEGRAL_LIMIT = 3'd6;
   localparam logic [CSR_IW-1:0] CSR_SERVO_DIVIDE   = 3'd7;

   // Last direction seen by the encoder, used to bridge a skipped phase.
   localparam logic signed [2:0] DIR_NONE = 3'sd0;
   localparam logic signed [2:0] DIR_UP   = 3'sd2;
   localparam logic signed [2:0] DIR_DOWN = -3'sd2;

   // Operand request for the shared multiplier.
   typedef struct packed {
      logic                     go;
      logic [MUL_AW-1:0]        a;
      logic signed [MUL_BW-1:0] b;
   } mul_op_type;

   // Gray order of the pin pair (B, A): 00, 01, 11, 10.
   function automatic logic [1:0] phase_of_pins(input logic pin_b, input logic pin_a);
      logic [1:0] phase;
      case ({pin_b, pin_a})
         2'b00:   phase = 2'd0;
         2'b01:   phase = 2'd1;
         2'b11:   phase = 2'd2;
         2'b10:   phase = 2'd3;
         default: phase = 2'd0;
      endcase
      return phase;
   endfunction

endpackage

>>> rtl/epmd_mul.sv
// ----------------------------------------------------------------------------
// epmd_mul: shared multiplier of the servo sequencer
// Unsigned by signed product with a registered result.
// ----------------------------------------------------------------------------
module epmd_mul import epmd_pkg::*; (
   input  logic                     clock,
   input  mul_op_type               op,
   output logic signed [MUL_PW-1:0] prod_ff
);

   logic signed [MUL_AW+MUL_BW-1:0] full;
   logic signed [MUL_PW-1:0]        prod_in;

   assign full    = $signed({1'b0, op.a}) * op.b;
   // The magnitude of the product stays below 2^49.
   assign prod_in = $signed(full[MUL_PW-1:0]);

   always_ff @(posedge clock) begin
      if (op.go) begin
         prod_ff <= prod_in;
      end
   end

endmodule

>>> rtl/encoder_pid_motor_drive_top.sv
// ----------------------------------------------------------------------------
// encoder_pid_motor_drive_top: one motor channel with encoder and speed loop
// Quadrature decode, servo tick, ring-based speed, PID and scaled PWM drive.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the req_ channel carries one sample of the two encoder pins
// and the supply voltage; the sample is decoded in the cycle it is taken.
// Every servo_divide samples a servo tick runs and exactly one transfer leaves
// on the rsp_ channel; other samples give no result and the next one can
// follow at once.
// A tick holds req_stall high until its result is registered: in speed mode the
// sequencer runs the PID through one shared multiplier, then scales the command
// by REF_MV / supply with a restoring divider that yields one quotient bit per
// cycle into a 12-bit quotient. Direct PWM mode skips six PID steps.
// A saturated drive or a zero command skips the divider.
// The result sits in an output register. New samples are taken while it waits;
// only the end of the next tick waits for the register to be free, so a
// stalled receiver backs up into req_stall only after a second tick.
// Reset is synchronous and active high and restores register defaults and all
// state but supply_ff and datapath registers. req_stall is high and csr_ready
// low during reset; registers must be written while the block is idle.
// ----------------------------------------------------------------------------
module encoder_pid_motor_drive_top import epmd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // Sample channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_pin_a,
   input  logic               req_pin_b,
   input  logic [15:0]        req_supply_mv,
   // Result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_drive_forward,
   output logic [15:0]        rsp_drive_reverse,
   output logic signed [31:0] rsp_speed_now,
   output logic signed [31:0] rsp_position_count,
   output logic [15:0]        rsp_missed_steps,
   // Register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_IW-1:0]  csr_index,
   input  logic [CSR_DW-1:0]  csr_data
);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SPEED = 4'd1;
   localparam logic [3:0] ST_ERR   = 4'd2;
   localparam logic [3:0] ST_MI    = 4'd3;
   localparam logic [3:0] ST_INT   = 4'd4;
   localparam logic [3:0] ST_P     = 4'd5;
   localparam logic [3:0] ST_D     = 4'd6;
   localparam logic [3:0] ST_SAT   = 4'd7;
   localparam logic [3:0] ST_MAG   = 4'd8;
   localparam logic [3:0] ST_LIM   = 4'd9;
   localparam logic [3:0] ST_CMP   = 4'd10;
   localparam logic [3:0] ST_DIV   = 4'd11;
   localparam logic [3:0] ST_OUT   = 4'd12;

   // Phase differences between two samples.
   localparam logic [1:0] STEP_HOLD = 2'd0;
   localparam logic [1:0] STEP_UP   = 2'd1;
   localparam logic [1:0] STEP_SKIP = 2'd2;
   localparam logic [1:0] STEP_DOWN = 2'd3;

   localparam logic signed [MUL_PW-1:0] CMD_MAX = 50'sh7FFFFFFF;
   localparam logic signed [MUL_PW-1:0] CMD_MIN = -50'sh80000000;
   localparam logic [15:0] PWM_MAX_W  = 16'(PWM_MAX);
   localparam logic [15:0] FRICTION_W = 16'(FRICTION_PWM);

   // Configuration registers.
   logic                   control_mode_ff;
   logic signed [15:0]     speed_target_ff;
   logic signed [16:0]     manual_command_ff;
   logic [9:0]             gain_p_ff;
   logic [9:0]             gain_i_ff;
   logic [9:0]             gain_d_ff;
   logic [19:0]            integral_limit_ff;
   logic [15:0]            servo_divide_ff;

   // Encoder and servo state.
   logic [3:0]             state_ff;
   logic [1:0]             last_phase_ff;
   logic signed [2:0]      last_dir_ff;
   logic [31:0]            position_ff;
   logic [15:0]            error_total_ff;
   logic [15:0]            sample_div_ff;
   logic [31:0]            ring_ff [SPEED_WINDOW];
   logic [RING_IW-1:0]     ring_index_ff;
   logic signed [31:0]     speed_ff;
   logic signed [31:0]     prev_speed_ff;
   logic signed [20:0]     integral_ff;
   logic signed [31:0]     cmd_ff;
   logic [15:0]            supply_ff;

   // Working registers of the sequencer.
   logic signed [33:0]     err_ff;
   logic signed [32:0]     dspd_ff;
   logic signed [MUL_PW-1:0] acc_ff;
   logic [47:0]            numer_ff;
   logic [15:0]            rem_ff;
   logic [QUOT_W-1:0]      quot_ff;
   logic [DIV_CW-1:0]      div_cnt_ff;
   logic [15:0]            mag_ff;

   // Result register.
   logic                   rsp_valid_ff;
   logic [15:0]            rsp_fwd_ff;
   logic [15:0]            rsp_rev_ff;
   logic signed [31:0]     rsp_speed_ff;
   logic signed [31:0]     rsp_pos_ff;
   logic [15:0]            rsp_miss_ff;

   // Combinational helpers.
   logic                   req_accept;
   logic [1:0]             phase_now;
   logic [1:0]             phase_step;
   logic [31:0]            position_in;
   logic signed [2:0]      last_dir_in;
   logic [15:0]            error_total_in;
   logic [15:0]            div_next;
   logic                   servo_tick;
   logic [RING_IW-1:0]     ring_next_idx;
   logic [31:0]            mag_abs;
   logic                   cmd_zero;
   logic signed [50:0]     int_sum;
   logic signed [50:0]     int_lim;
   logic signed [20:0]     integral_in;
   logic [16:0]            div_trial;
   logic                   div_qbit;
   logic [15:0]            rem_in;
   logic [QUOT_W-1:0]      quot_in;
   logic [15:0]            drive_mag;
   logic                   out_free;
   mul_op_type             mul_op;
   logic signed [MUL_PW-1:0] prod;

   epmd_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .prod_ff (prod)
   );

   assign req_stall  = reset | (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = ~reset;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   // Quadrature decode of the incoming sample.
   always_comb begin
      phase_now      = phase_of_pins(req_pin_b, req_pin_a);
      phase_step     = phase_now - last_phase_ff;
      position_in    = position_ff;
      last_dir_in    = last_dir_ff;
      error_total_in = error_total_ff;
      case (phase_step)
         STEP_UP: begin
            position_in = position_ff + 32'd1;
            last_dir_in = DIR_UP;
         end
         STEP_DOWN: begin
            position_in = position_ff - 32'd1;
            last_dir_in = DIR_DOWN;
         end
         STEP_SKIP: begin
            // A skipped phase is bridged with twice the last direction.
            position_in = position_ff + {{29{last_dir_ff[2]}}, last_dir_ff};
            if (error_total_ff != 16'hFFFF) begin
               error_total_in = error_total_ff + 16'd1;
            end
         end
         STEP_HOLD: begin
            position_in = position_ff;
         end
         default: begin
            position_in = position_ff;
         end
      endcase
   end

   assign div_next      = sample_div_ff + 16'd1;
   assign servo_tick    = (div_next >= servo_divide_ff);
   assign ring_next_idx = (ring_index_ff == RING_IW'(SPEED_WINDOW - 1)) ? '0
                                                                        : ring_index_ff + 1'b1;

   assign mag_abs  = cmd_ff[31] ? (~cmd_ff + 32'd1) : cmd_ff;
   assign cmd_zero = (cmd_ff == 32'sd0);

   // Integral update with its symmetric clamp.
   always_comb begin
      int_sum = {{30{integral_ff[20]}}, integral_ff} + {prod[MUL_PW-1], prod};
      int_lim = $signed({31'd0, integral_limit_ff});
      if (int_sum > int_lim) begin
         integral_in = int_lim[20:0];
      end else if (int_sum < -int_lim) begin
         integral_in = 21'(-int_lim);
      end else begin
         integral_in = int_sum[20:0];
      end
   end

   // One restoring division step.
   always_comb begin
      div_trial = {rem_ff, numer_ff[QUOT_W-1]};
      div_qbit  = (div_trial >= {1'b0, supply_ff});
      rem_in    = div_qbit ? 16'(div_trial - {1'b0, supply_ff}) : div_trial[15:0];
      quot_in   = QUOT_W'({quot_ff, div_qbit});
   end

   // Friction lift of a small nonzero duty.
   assign drive_mag = ((mag_ff != 16'd0) && (mag_ff < FRICTION_W)) ? FRICTION_W : mag_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_op.go = 1'b1;
      mul_op.a  = '0;
      mul_op.b  = '0;
      case (state_ff)
         ST_MI: begin
            mul_op.a = {6'd0, gain_i_ff};
            mul_op.b = err_ff;
         end
         ST_INT: begin
            mul_op.a = {6'd0, gain_p_ff};
            mul_op.b = err_ff;
         end
         ST_P: begin
            mul_op.a = {6'd0, gain_d_ff};
            mul_op.b = {dspd_ff[32], dspd_ff};
         end
         ST_MAG: begin
            mul_op.a = 16'(REF_MV);
            mul_op.b = $signed({2'b00, mag_abs});
         end
         ST_LIM: begin
            mul_op.a = supply_ff;
            mul_op.b = 34'(PWM_MAX + 1);
         end
         default: begin
            mul_op.go = 1'b0;
         end
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         control_mode_ff   <= 1'b0;
         speed_target_ff   <= '0;
         manual_command_ff <= '0;
         gain_p_ff         <= 10'd20;
         gain_i_ff         <= 10'd3;
         gain_d_ff         <= 10'd2;
         integral_limit_ff <= 20'd65535;
         servo_divide_ff   <= 16'd20;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CONTROL_MODE:   control_mode_ff   <= csr_data[0];
            CSR_SPEED_TARGET:   speed_target_ff   <= $signed(csr_data[15:0]);
            CSR_MANUAL_COMMAND: manual_command_ff <= $signed(csr_data[16:0]);
            CSR_GAIN_P:         gain_p_ff         <= csr_data[9:0];
            CSR_GAIN_I:         gain_i_ff         <= csr_data[9:0];
            CSR_GAIN_D:         gain_d_ff         <= csr_data[9:0];
            CSR_INTEGRAL_LIMIT: integral_limit_ff <= csr_data[19:0];
            CSR_SERVO_DIVIDE:   servo_divide_ff   <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer and servo datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_phase_ff  <= 2'd0;
         last_dir_ff    <= DIR_NONE;
         position_ff    <= '0;
         error_total_ff <= '0;
         sample_div_ff  <= '0;
         ring_index_ff  <= '0;
         speed_ff       <= '0;
         prev_speed_ff  <= '0;
         integral_ff    <= '0;
         cmd_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < SPEED_WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         // In ST_OUT the result register is refilled or held below instead.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  last_phase_ff  <= phase_now;
                  last_dir_ff    <= last_dir_in;
                  position_ff    <= position_in;
                  error_total_ff <= error_total_in;
                  supply_ff      <= req_supply_mv;
                  if (servo_tick) begin
                     sample_div_ff           <= '0;
                     ring_ff[ring_index_ff]  <= position_in;
                     ring_index_ff           <= ring_next_idx;
                     state_ff                <= ST_SPEED;
                  end else begin
                     sample_div_ff <= div_next;
                  end
               end
            end
            ST_SPEED: begin
               // The ring index now points at the oldest entry of the window.
               speed_ff      <= $signed(position_ff - ring_ff[ring_index_ff]);
               prev_speed_ff <= speed_ff;
               if (control_mode_ff) begin
                  cmd_ff   <= {{15{manual_command_ff[16]}}, manual_command_ff};
                  state_ff <= ST_MAG;
               end else begin
                  state_ff <= ST_ERR;
               end
            end
            ST_ERR: begin
               err_ff   <= {{18{speed_target_ff[15]}}, speed_target_ff}
                           - {{2{speed_ff[31]}}, speed_ff};
               dspd_ff  <= {speed_ff[31], speed_ff} - {prev_speed_ff[31], prev_speed_ff};
               state_ff <= ST_MI;
            end
            ST_MI: begin
               state_ff <= ST_INT;
            end
            ST_INT: begin
               integral_ff <= integral_in;
               state_ff    <= ST_P;
            end
            ST_P: begin
               acc_ff   <= prod + {{(MUL_PW-21){integral_ff[20]}}, integral_ff};
               state_ff <= ST_D;
            end
            ST_D: begin
               acc_ff   <= acc_ff + prod;
               state_ff <= ST_SAT;
            end
            ST_SAT: begin
               if (acc_ff > CMD_MAX) begin
                  cmd_ff <= 32'sh7FFFFFFF;
               end else if (acc_ff < CMD_MIN) begin
                  cmd_ff <= 32'sh80000000;
               end else begin
                  cmd_ff <= acc_ff[31:0];
               end
               state_ff <= ST_MAG;
            end
            ST_MAG: begin
               state_ff <= ST_LIM;
            end
            ST_LIM: begin
               numer_ff <= prod[47:0];
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               // The product holds (PWM_MAX + 1) * supply; at or above it the
               // drive saturates, which also covers a supply of zero.
               if (cmd_zero) begin
                  mag_ff   <= '0;
                  state_ff <= ST_OUT;
               end else if (numer_ff >= prod[47:0]) begin
                  mag_ff   <= PWM_MAX_W;
                  state_ff <= ST_OUT;
               end else begin
                  rem_ff     <= numer_ff[QUOT_W+15:QUOT_W];
                  quot_ff    <= '0;
                  div_cnt_ff <= DIV_CW'(QUOT_W - 1);
                  state_ff   <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff     <= rem_in;
               quot_ff    <= quot_in;
               numer_ff   <= numer_ff << 1;
               div_cnt_ff <= div_cnt_ff - 1'b1;
               if (div_cnt_ff == '0) begin
                  mag_ff   <= 16'(quot_in);
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_fwd_ff   <= (!cmd_ff[31] && !cmd_zero) ? drive_mag : 16'd0;
                  rsp_rev_ff   <= cmd_ff[31] ? drive_mag : 16'd0;
                  rsp_speed_ff <= speed_ff;
                  rsp_pos_ff   <= $signed(position_ff);
                  rsp_miss_ff  <= error_total_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_forward  = rsp_fwd_ff;
   assign rsp_drive_reverse  = rsp_rev_ff;
   assign rsp_speed_now      = rsp_speed_ff;
   assign rsp_position_count = rsp_pos_ff;
   assign rsp_missed_steps   = rsp_miss_ff;

endmodule
